// File: rtl/gbts_pkg.sv
// Package for the gap buffer text store: field widths, action and status codes,
// and the sequencer state type. No dependencies; every other file imports it.
`default_nettype none

package gbts_pkg;

  localparam int CAPACITY_DEF = 1024;

  localparam int ACTION_W = 3;
  localparam int POS_W    = 11;
  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 3;
  localparam int LEN_W    = 11;

  localparam logic [ACTION_W-1:0] ACT_INSERT    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_DEL_BYTE  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_DEL_RANGE = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_READ      = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_MOVE_GAP  = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_CLEAR     = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_CLEAR_MOD = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_POS = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BOUNDS  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RO      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MOVE,
    S_EXEC,
    S_READ,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

// File: rtl/gbts_if.sv
// Channel interfaces of the gap buffer text store: request, response and
// configuration write. Depends on gbts_pkg for the field widths.
`default_nettype none

interface gbts_req_if import gbts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [POS_W-1:0]    position;
  logic [POS_W-1:0]    end_position;
  logic [CHAR_W-1:0]   char_in;

  modport source (output valid, action, position, end_position, char_in, input ready);
  modport sink   (input valid, action, position, end_position, char_in, output ready);
endinterface

interface gbts_rsp_if import gbts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CHAR_W-1:0]   char_out;
  logic [LEN_W-1:0]    text_length;
  logic                modified;

  modport source (output valid, status, char_out, text_length, modified, input ready);
  modport sink   (input valid, status, char_out, text_length, modified, output ready);
endinterface

interface gbts_cfg_if ();
  logic valid;
  logic ready;
  logic write_protect;

  modport source (output valid, write_protect, input ready);
  modport sink   (input valid, write_protect, output ready);
endinterface

`default_nettype wire

// File: rtl/gap_buffer_text_store.sv
// Top level of the gap buffer text store: request checks, gap move sequencer
// and response register. Depends on gbts_pkg, gbts_if.sv and gbts_mem.
//
//   channel  modport  beat carries
//   req      sink     action, position, end_position, char_in
//   rsp      source   status, char_out, text_length, modified
//   cfg      sink     write_protect
//
// A gap move passes the check, move, execute and response states before the
// next request beat: the byte store has one read and one write port, so the
// gap moves one byte per cycle. Reads use check, read and response states.
// Reset gives an empty text with the whole store as gap; the store itself is
// not cleared. A stalled response is held in its register while the next
// request is accepted; a second result waits until the first beat is taken.
`default_nettype none

module gap_buffer_text_store import gbts_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  gbts_req_if.sink   req,
  gbts_rsp_if.source rsp,
  gbts_cfg_if.sink   cfg
);

  // Pointer width holds 0..CAPACITY; the compare width also covers the
  // 11-bit request positions, so no position is truncated before checking.
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = (PW > POS_W) ? PW : POS_W;
  localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

  state_t state, state_next;

  // Latched request.
  logic [ACTION_W-1:0] act, act_next;
  logic [CW-1:0]       pos_c, pos_c_next;
  logic [CW-1:0]       endp_c, endp_c_next;
  logic [CHAR_W-1:0]   ch, ch_next;

  // Gap pointers and flags.
  logic [PW-1:0] gf, gf_next;
  logic [PW-1:0] gpe, gpe_next;
  logic [PW-1:0] tgt, tgt_next;
  logic          dirty, dirty_next;
  logic          ro;

  // Result under construction.
  logic [STATUS_W-1:0] st, st_next;
  logic [CHAR_W-1:0]   rd, rd_next;

  // A byte read during a gap step is written in the following cycle.
  logic          pend_valid, pend_valid_next;
  logic [AW-1:0] pend_addr, pend_addr_next;

  // Response register.
  logic                out_valid, out_valid_next;
  logic [STATUS_W-1:0] out_status, out_status_next;
  logic [CHAR_W-1:0]   out_char, out_char_next;
  logic [LEN_W-1:0]    out_len, out_len_next;
  logic                out_mod, out_mod_next;

  // Memory ports.
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [CHAR_W-1:0] mem_rdata;
  logic              exec_we;

  // Derived values.
  logic [PW-1:0] hole, len, gf_dec, gpe_dec, pos_p, endp_p, rd_addr;
  logic [CW-1:0] len_c;
  logic          edit;

  assign hole    = gpe - gf;
  assign len     = CAP_P - hole;
  assign len_c   = CW'(len);
  assign gf_dec  = gf - 1'b1;
  assign gpe_dec = gpe - 1'b1;
  assign pos_p   = pos_c[PW-1:0];
  assign endp_p  = endp_c[PW-1:0];
  assign rd_addr = (pos_p < gf) ? pos_p : (pos_p + hole);
  assign edit    = act inside {ACT_INSERT, ACT_DEL_BYTE, ACT_DEL_RANGE, ACT_CLEAR};

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.char_out    = out_char;
  assign rsp.text_length = out_len;
  assign rsp.modified    = out_mod;

  // Write port: a pending gap-step byte always wins; the insert write only
  // happens in the execute state, when no step is pending.
  assign mem_we    = pend_valid | exec_we;
  assign mem_waddr = pend_valid ? pend_addr : gf[AW-1:0];
  assign mem_wdata = pend_valid ? mem_rdata : ch;

  gbts_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      gf         <= '0;
      gpe        <= CAP_P;
      dirty      <= 1'b0;
      ro         <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      gf         <= gf_next;
      gpe        <= gpe_next;
      dirty      <= dirty_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
      if (cfg.valid) begin
        ro <= cfg.write_protect;
      end
    end
  end

  always_ff @(posedge clk) begin
    act        <= act_next;
    pos_c      <= pos_c_next;
    endp_c     <= endp_c_next;
    ch         <= ch_next;
    tgt        <= tgt_next;
    st         <= st_next;
    rd         <= rd_next;
    pend_addr  <= pend_addr_next;
    out_status <= out_status_next;
    out_char   <= out_char_next;
    out_len    <= out_len_next;
    out_mod    <= out_mod_next;
  end

  always_comb begin
    state_next      = state;
    act_next        = act;
    pos_c_next      = pos_c;
    endp_c_next     = endp_c;
    ch_next         = ch;
    gf_next         = gf;
    gpe_next        = gpe;
    tgt_next        = tgt;
    dirty_next      = dirty;
    st_next         = st;
    rd_next         = rd;
    pend_valid_next = 1'b0;
    pend_addr_next  = pend_addr;
    out_valid_next  = out_valid & ~rsp.ready;
    out_status_next = out_status;
    out_char_next   = out_char;
    out_len_next    = out_len;
    out_mod_next    = out_mod;
    mem_raddr       = rd_addr[AW-1:0];
    exec_we         = 1'b0;

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          act_next    = req.action;
          pos_c_next  = CW'(req.position);
          endp_c_next = CW'(req.end_position);
          ch_next     = req.char_in;
          state_next  = S_CHECK;
        end
      end

      S_CHECK: begin
        st_next    = ST_OK;
        rd_next    = '0;
        tgt_next   = pos_p;
        state_next = S_RESP;
        if (edit && ro) begin
          st_next = ST_RO;
        end else begin
          case (act)
            ACT_INSERT: begin
              if (pos_c > len_c) begin
                st_next = ST_BAD_POS;
              end else if (hole == '0) begin
                st_next = ST_FULL;
              end else begin
                state_next = S_MOVE;
              end
            end
            ACT_DEL_BYTE: begin
              if (pos_c >= len_c) begin
                st_next = ST_BOUNDS;
              end else begin
                state_next = S_MOVE;
              end
            end
            ACT_DEL_RANGE: begin
              if (pos_c > len_c || endp_c > len_c || pos_c > endp_c) begin
                st_next = ST_BOUNDS;
              end else if (pos_c != endp_c) begin
                state_next = S_MOVE;
              end
            end
            ACT_READ: begin
              // The read address is already on the port in this state.
              if (pos_c >= len_c) begin
                st_next = ST_BOUNDS;
              end else begin
                state_next = S_READ;
              end
            end
            ACT_MOVE_GAP: begin
              if (pos_c > len_c) begin
                st_next = ST_BAD_POS;
              end else begin
                state_next = S_MOVE;
              end
            end
            ACT_CLEAR: begin
              gf_next    = '0;
              gpe_next   = CAP_P;
              dirty_next = 1'b1;
            end
            ACT_CLEAR_MOD: begin
              dirty_next = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      S_MOVE: begin
        // One byte per cycle across the gap. Moving left copies the byte just
        // before the gap to the top end of the gap; moving right copies the
        // byte just after the gap down to its bottom end.
        if (gf == tgt) begin
          state_next = S_EXEC;
        end else if (tgt < gf) begin
          mem_raddr       = gf_dec[AW-1:0];
          pend_valid_next = 1'b1;
          pend_addr_next  = gpe_dec[AW-1:0];
          gf_next         = gf_dec;
          gpe_next        = gpe_dec;
        end else begin
          mem_raddr       = gpe[AW-1:0];
          pend_valid_next = 1'b1;
          pend_addr_next  = gf[AW-1:0];
          gf_next         = gf + 1'b1;
          gpe_next        = gpe + 1'b1;
        end
      end

      S_EXEC: begin
        state_next = S_RESP;
        case (act)
          ACT_INSERT: begin
            exec_we    = 1'b1;
            gf_next    = gf + 1'b1;
            dirty_next = 1'b1;
          end
          ACT_DEL_BYTE: begin
            gpe_next   = gpe + 1'b1;
            dirty_next = 1'b1;
          end
          ACT_DEL_RANGE: begin
            gpe_next   = gpe + (endp_p - pos_p);
            dirty_next = 1'b1;
          end
          default: begin
          end
        endcase
      end

      S_READ: begin
        rd_next    = mem_rdata;
        state_next = S_RESP;
      end

      S_RESP: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next  = 1'b1;
          out_status_next = st;
          out_char_next   = rd;
          out_len_next    = len_c[LEN_W-1:0];
          out_mod_next    = dirty;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/gbts_mem.sv
// Byte store of the gap buffer: one write port, one read port, registered read.
// Depends on gbts_pkg for the byte width.
`default_nettype none

module gbts_mem import gbts_pkg::*; #(
  parameter int DEPTH = CAPACITY_DEF,
  parameter int AW    = $clog2(CAPACITY_DEF)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [CHAR_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [CHAR_W-1:0] rdata
);

  logic [CHAR_W-1:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= store[raddr];
  end

endmodule

`default_nettype wire
